>>> sv/square_free_suffix_checker_top_defines.svh
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers shared by the checker RTL; empty in synthesis.
// ============================================================================
`ifndef SQUARE_FREE_SUFFIX_CHECKER_TOP_DEFINES_SVH
`define SQUARE_FREE_SUFFIX_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SFSC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sfsc assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define SFSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfsc assertion failed");
`else
`define SFSC_ASSERT(label, prop)
`define SFSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/sfsc_pkg.sv
// ============================================================================
// sfsc_pkg
// Shared constants, codes and status types of the square-free suffix checker.
// ============================================================================
package sfsc_pkg;

   localparam int MAX_LEN_DEF     = 1024;
   localparam int SYMBOL_BITS_DEF = 2;
   localparam int STRIDE_W        = 11;
   localparam int ERR_W           = 2;
   localparam int CSR_IDX_W       = 1;

   // command codes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_P = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_Q = 1'b1;

   localparam logic [STRIDE_W-1:0] STRIDE_P_RST = 11'd3;
   localparam logic [STRIDE_W-1:0] STRIDE_Q_RST = 11'd4;

   typedef struct packed {
      logic done;
      logic zero;
   } rem_sts_type;

   typedef struct packed {
      logic done;
      logic ok;
   } scan_sts_type;

endpackage

>>> sv/sfsc_req_if.sv
// ============================================================================
// sfsc_req_if
// Command channel: append or remove-last, with the symbol to append.
// ============================================================================
interface sfsc_req_if #(
   parameter int SYMBOL_BITS = sfsc_pkg::SYMBOL_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [SYMBOL_BITS-1:0] symbol;

   modport source (output valid, operation, symbol, input ready);
   modport sink   (input valid, operation, symbol, output ready);
endinterface

>>> sv/sfsc_rsp_if.sv
// ============================================================================
// sfsc_rsp_if
// Result channel: check flags, word length and error code.
// ============================================================================
interface sfsc_rsp_if #(
   parameter int LEN_W = $clog2(sfsc_pkg::MAX_LEN_DEF + 1)
);
   import sfsc_pkg::*;

   logic             valid;
   logic             ready;
   logic             plain_ok;
   logic             stride_p_ok;
   logic             stride_q_ok;
   logic             all_ok;
   logic [LEN_W-1:0] word_length;
   logic [ERR_W-1:0] error_code;

   modport source (output valid, plain_ok, stride_p_ok, stride_q_ok, all_ok,
                   word_length, error_code, input ready);
   modport sink   (input valid, plain_ok, stride_p_ok, stride_q_ok, all_ok,
                   word_length, error_code, output ready);
endinterface

>>> sv/sfsc_csr_if.sv
// ============================================================================
// sfsc_csr_if
// Register write channel: register index and write data.
// ============================================================================
interface sfsc_csr_if;
   import sfsc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [STRIDE_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/square_free_suffix_checker_top.sv
// ============================================================================
// square_free_suffix_checker_top
// Word store with append and remove-last, checking the word end for squares.
// ============================================================================
// The word lives in a MAX_LEN-entry RAM with two registered read ports. A
// remove, or an append to a full store, goes from idle to the emit state,
// which loads its result into the output register once that register is
// free, and the sequencer is then back in idle for the next item. An append
// runs three checks in turn: plain, stride p, stride q.
// Each check first takes the remainder of the new position by its stride,
// one bit a cycle; when that remainder is zero it walks the periods
// 1 .. samples/2, reading one pair of stored symbols a cycle through both
// read ports. The walk over a period runs until a mismatch or a square, so
// the plain check, with the most samples, takes longest on a long word. One
// item is worked on at a time; the next item is taken once the result is in
// the output register, which holds it until the sink takes it. The RAM needs
// no clearing: only written entries are ever read, and reads start only
// after the append's write is done.
// ============================================================================
`include "square_free_suffix_checker_top_defines.svh"

module square_free_suffix_checker_top #(
   parameter int MAX_LEN     = sfsc_pkg::MAX_LEN_DEF,
   parameter int SYMBOL_BITS = sfsc_pkg::SYMBOL_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sfsc_req_if.sink   req_port,
   sfsc_rsp_if.source rsp_port,
   sfsc_csr_if.sink   csr_port
);
   import sfsc_pkg::*;

   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int LEN_W  = $clog2(MAX_LEN + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_REM  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   // check being run; also the bit of the flag vector it sets
   localparam logic [1:0] CHK_PLAIN = 2'd0;
   localparam logic [1:0] CHK_P     = 2'd1;
   localparam logic [1:0] CHK_Q     = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [STRIDE_W-1:0] sp_ff, sp_in;
   logic [STRIDE_W-1:0] sq_ff, sq_in;
   logic [1:0]          chk_ff, chk_in;
   logic [2:0]          flags_ff, flags_in;
   logic [ERR_W-1:0]    err_ff, err_in;
   logic                rem_go_ff, rem_go_in;
   logic                scan_go_ff, scan_go_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_flags_ff, rsp_flags_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic [ERR_W-1:0]    rsp_err_ff, rsp_err_in;

   logic                accept;
   logic                full;
   logic                chk_done;
   logic                chk_ok;
   logic [STRIDE_W-1:0] cur_step;
   logic [ADDR_W-1:0]   last_addr;
   logic [ADDR_W-1:0]   rd_addr_a;
   logic [ADDR_W-1:0]   rd_addr_b;
   logic [SYMBOL_BITS-1:0] rd_data_a;
   logic [SYMBOL_BITS-1:0] rd_data_b;
   logic                wr_en;
   rem_sts_type         rem_sts;
   scan_sts_type        scan_sts;

   // take a command only when no earlier one is still in work
   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign full           = (len_ff == LEN_W'(MAX_LEN));
   assign csr_port.ready = 1'b1;

   // the append writes at the old length; the checks read only after that write
   assign wr_en     = accept && (req_port.operation == OP_APPEND) && !full;
   assign last_addr = ADDR_W'(len_ff - 1'b1);

   // stride zero acts as stride one
   always_comb begin
      unique case (chk_ff)
         CHK_PLAIN: cur_step = STRIDE_W'(1);
         CHK_P:     cur_step = (sp_ff == '0) ? STRIDE_W'(1) : sp_ff;
         CHK_Q:     cur_step = (sq_ff == '0) ? STRIDE_W'(1) : sq_ff;
         default:   cur_step = STRIDE_W'(1);
      endcase
   end

   // a check ends when its position is off the stride grid, or when the
   // period walk finishes
   always_comb begin
      chk_done = 1'b0;
      chk_ok   = 1'b1;
      if ((state_ff == ST_REM) && rem_sts.done) begin
         chk_done = !rem_sts.zero;
         chk_ok   = 1'b1;
      end else if ((state_ff == ST_SCAN) && scan_sts.done) begin
         chk_done = 1'b1;
         chk_ok   = scan_sts.ok;
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      sp_in        = sp_ff;
      sq_in        = sq_ff;
      chk_in       = chk_ff;
      flags_in     = flags_ff;
      err_in       = err_ff;
      rem_go_in    = 1'b0;
      scan_go_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_err_in   = rsp_err_ff;

      if (csr_port.valid && csr_port.ready) begin
         unique case (csr_port.index)
            CSR_STRIDE_P: sp_in = csr_port.data;
            CSR_STRIDE_Q: sq_in = csr_port.data;
            default:      sp_in = sp_ff;
         endcase
      end

      // drop the output item once the sink has it
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_port.operation == OP_APPEND) begin
                  if (full) begin
                     flags_in = 3'b000;
                     err_in   = ERR_FULL;
                     state_in = ST_EMIT;
                  end else begin
                     len_in    = len_ff + 1'b1;
                     err_in    = ERR_NONE;
                     flags_in  = 3'b111;
                     chk_in    = CHK_PLAIN;
                     rem_go_in = 1'b1;
                     state_in  = ST_REM;
                  end
               end else begin
                  flags_in = 3'b111;
                  if (len_ff == '0) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     len_in = len_ff - 1'b1;
                     err_in = ERR_NONE;
                  end
                  state_in = ST_EMIT;
               end
            end
         end
         ST_REM, ST_SCAN: begin
            if ((state_ff == ST_REM) && rem_sts.done && rem_sts.zero) begin
               // position on the grid: walk the periods
               scan_go_in = 1'b1;
               state_in   = ST_SCAN;
            end else if (chk_done) begin
               flags_in[chk_ff] = chk_ok;
               if (chk_ff == CHK_Q) begin
                  state_in = ST_EMIT;
               end else begin
                  chk_in    = chk_ff + 1'b1;
                  rem_go_in = 1'b1;
                  state_in  = ST_REM;
               end
            end
         end
         ST_EMIT: begin
            // hold the finished item until the output register is free
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_flags_in = flags_ff;
               rsp_len_in   = len_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         sp_ff        <= STRIDE_P_RST;
         sq_ff        <= STRIDE_Q_RST;
         rem_go_ff    <= 1'b0;
         scan_go_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         sp_ff        <= sp_in;
         sq_ff        <= sq_in;
         rem_go_ff    <= rem_go_in;
         scan_go_ff   <= scan_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_ff       <= chk_in;
      flags_ff     <= flags_in;
      err_ff       <= err_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.plain_ok    = rsp_flags_ff[CHK_PLAIN];
   assign rsp_port.stride_p_ok = rsp_flags_ff[CHK_P];
   assign rsp_port.stride_q_ok = rsp_flags_ff[CHK_Q];
   assign rsp_port.all_ok      = &rsp_flags_ff;
   assign rsp_port.word_length = rsp_len_ff;
   assign rsp_port.error_code  = rsp_err_ff;

   sfsc_ram #(
      .WIDTH (SYMBOL_BITS),
      .DEPTH (MAX_LEN)
   ) u_word_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (len_ff[ADDR_W-1:0]),
      .wr_data   (req_port.symbol),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   sfsc_rem #(
      .DIVIDEND_W (ADDR_W)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .go       (rem_go_ff),
      .dividend (last_addr),
      .divisor  (cur_step),
      .sts      (rem_sts)
   );

   sfsc_scan #(
      .ADDR_W (ADDR_W),
      .SYM_W  (SYMBOL_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .go        (scan_go_ff),
      .last      (last_addr),
      .step      (cur_step),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .sts       (scan_sts)
   );

   // the length never runs past the store
   `SFSC_ASSERT(a_len_bound, len_ff <= LEN_W'(MAX_LEN))
   // unit completions arrive only while the sequencer waits for them
   `SFSC_ASSERT(a_rem_in_rem, rem_sts.done |-> state_ff == ST_REM)
   `SFSC_ASSERT(a_scan_in_scan, scan_sts.done |-> state_ff == ST_SCAN)
   // a successful append grows the word by exactly one symbol
   `SFSC_ASSERT_NEXT(a_append_grows, wr_en, len_ff == $past(len_ff) + 1'b1)
   // a refused append never reports a passing word
   `SFSC_ASSERT(a_full_fails, (rsp_valid_ff && rsp_err_ff == ERR_FULL) |-> !(&rsp_flags_ff))

endmodule

>>> sv/sfsc_ram.sv
// ============================================================================
// sfsc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module sfsc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

>>> sv/sfsc_rem.sv
// ============================================================================
// sfsc_rem
// Remainder of a position by a stride, restoring, one dividend bit a cycle.
// ============================================================================
module sfsc_rem #(
   parameter int DIVIDEND_W = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [DIVIDEND_W-1:0]         dividend,
   input  logic [sfsc_pkg::STRIDE_W-1:0] divisor,
   output sfsc_pkg::rem_sts_type         sts
);
   import sfsc_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [STRIDE_W-1:0]   rem_ff, rem_in;
   logic [STRIDE_W:0]     trial;
   logic [STRIDE_W:0]     diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // trial stays below the divisor when it does not fit
         rem_in = fits ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
         quo_in = quo_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign sts.done = done_ff;
   assign sts.zero = (rem_ff == '0);
endmodule

>>> sv/sfsc_scan.sv
// ============================================================================
// sfsc_scan
// Square search at the word end: walks periods, one stored pair a cycle.
// ============================================================================
module sfsc_scan #(
   parameter int ADDR_W = 10,
   parameter int SYM_W  = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [ADDR_W-1:0]             last,
   input  logic [sfsc_pkg::STRIDE_W-1:0] step,
   output logic [ADDR_W-1:0]             rd_addr_a,
   output logic [ADDR_W-1:0]             rd_addr_b,
   input  logic [SYM_W-1:0]              rd_data_a,
   input  logic [SYM_W-1:0]              rd_data_b,
   output sfsc_pkg::scan_sts_type        sts
);
   import sfsc_pkg::*;

   localparam int SW = ((ADDR_W > STRIDE_W) ? ADDR_W : STRIDE_W) + 3;

   typedef logic signed [SW-1:0] pos_type;

   logic      run_ff, run_in;
   logic      issue_ff, issue_in;
   logic      cmp_vld_ff, cmp_vld_in;
   logic      cmp_last_ff, cmp_last_in;
   logic      done_ff, done_in;
   logic      ok_ff, ok_in;
   pos_type   a_ff, a_in;
   pos_type   b_ff, b_in;
   pos_type   low_ff, low_in;
   pos_type   bst_ff, bst_in;
   pos_type   last_ff, last_in;
   pos_type   step_ff, step_in;
   pos_type   go_last;
   pos_type   go_step;
   pos_type   go_low;
   pos_type   low_nx;
   pos_type   bst_nx;
   logic      mismatch;
   logic      square;

   assign go_last  = $signed({{(SW-ADDR_W){1'b0}}, last});
   assign go_step  = $signed({{(SW-STRIDE_W){1'b0}}, step});
   assign go_low   = go_last - go_step;
   assign low_nx   = low_ff - (step_ff + step_ff);
   assign bst_nx   = bst_ff - step_ff;
   assign mismatch = cmp_vld_ff && (rd_data_a != rd_data_b);
   assign square   = cmp_vld_ff && !mismatch && cmp_last_ff;

   assign rd_addr_a = a_ff[ADDR_W-1:0];
   assign rd_addr_b = b_ff[ADDR_W-1:0];

   always_comb begin
      run_in      = run_ff;
      issue_in    = issue_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_last_in = cmp_last_ff;
      done_in     = 1'b0;
      ok_in       = ok_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      low_in      = low_ff;
      bst_in      = bst_ff;
      last_in     = last_ff;
      step_in     = step_ff;
      if (go) begin
         last_in    = go_last;
         step_in    = go_step;
         low_in     = go_low;
         bst_in     = go_low;
         a_in       = go_last;
         b_in       = go_low;
         cmp_vld_in = 1'b0;
         // fewer than two samples: no period fits
         if (go_low < 0) begin
            run_in   = 1'b0;
            issue_in = 1'b0;
            done_in  = 1'b1;
            ok_in    = 1'b1;
         end else begin
            run_in   = 1'b1;
            issue_in = 1'b1;
         end
      end else if (run_ff) begin
         priority if (square) begin
            run_in     = 1'b0;
            issue_in   = 1'b0;
            cmp_vld_in = 1'b0;
            done_in    = 1'b1;
            ok_in      = 1'b0;
         end else if (mismatch) begin
            // drop the read in flight and move to the next period
            cmp_vld_in = 1'b0;
            if (low_nx < 0) begin
               run_in   = 1'b0;
               issue_in = 1'b0;
               done_in  = 1'b1;
               ok_in    = 1'b1;
            end else begin
               low_in   = low_nx;
               bst_in   = bst_nx;
               a_in     = last_ff;
               b_in     = bst_nx;
               issue_in = 1'b1;
            end
         end else if (issue_ff) begin
            cmp_vld_in  = 1'b1;
            cmp_last_in = (b_ff == low_ff);
            if (b_ff == low_ff) begin
               issue_in = 1'b0;
            end else begin
               a_in = a_ff - step_ff;
               b_in = b_ff - step_ff;
            end
         end else begin
            cmp_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         issue_ff   <= 1'b0;
         cmp_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         run_ff     <= run_in;
         issue_ff   <= issue_in;
         cmp_vld_ff <= cmp_vld_in;
         done_ff    <= done_in;
      end
      cmp_last_ff <= cmp_last_in;
      ok_ff       <= ok_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      low_ff      <= low_in;
      bst_ff      <= bst_in;
      last_ff     <= last_in;
      step_ff     <= step_in;
   end

   assign sts.done = done_ff;
   assign sts.ok   = ok_ff;
endmodule
